@@ sv/bdth_pkg.sv @@
// Shared constants and types for the button debounce / tap / hold block.
`timescale 1ns / 1ps
package bdth_pkg;

    // Width of the debounce and press timers.
    localparam int TIMER_WIDTH = 16;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Timers and 16-bit registers are compared at a common width.
    localparam int CMP_W = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;

    typedef logic [TIMER_WIDTH-1:0] timer_t;
    typedef logic [CFG_DATA_W-1:0]  ticks_t;

    localparam timer_t TIMER_MAX = {TIMER_WIDTH{1'b1}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACTIVE_LOW     = 2'd0,
        CFG_DEBOUNCE_TICKS = 2'd1,
        CFG_MIN_TAP_TICKS  = 2'd2,
        CFG_HOLD_TICKS     = 2'd3
    } cfg_index_t;

    localparam ticks_t RST_DEBOUNCE_TICKS = 16'd30;
    localparam ticks_t RST_MIN_TAP_TICKS  = 16'd30;
    localparam ticks_t RST_HOLD_TICKS     = 16'd1000;

    function automatic timer_t sat_inc(input timer_t v);
        timer_t r;
        r = (v == TIMER_MAX) ? TIMER_MAX : v + timer_t'(1);
        return r;
    endfunction

    // Unsigned a >= b with the timer zero-extended against a 16-bit register.
    function automatic logic timer_ge(input timer_t t, input ticks_t lim);
        logic [CMP_W-1:0] a;
        logic [CMP_W-1:0] b;
        a = CMP_W'(t);
        b = CMP_W'(lim);
        return (a >= b);
    endfunction

endpackage

@@ sv/bdth_if.sv @@
// Valid/ready channel interfaces for tick input beats and event result beats.
`timescale 1ns / 1ps
interface bdth_in_if;
    logic valid;
    logic ready;
    logic raw_level;
    logic resync;

    modport source (output valid, output raw_level, output resync, input ready);
    modport sink   (input valid, input raw_level, input resync, output ready);
    modport monitor (input valid, input raw_level, input resync, input ready);
endinterface

interface bdth_out_if;
    logic valid;
    logic ready;
    logic is_down;
    logic down_event;
    logic tap_event;
    logic hold_event;

    modport source (output valid, output is_down, output down_event,
                    output tap_event, output hold_event, input ready);
    modport sink   (input valid, input is_down, input down_event,
                    input tap_event, input hold_event, output ready);
    modport monitor (input valid, input is_down, input down_event,
                     input tap_event, input hold_event, input ready);
endinterface

@@ sv/button_debounce_tap_hold_top.sv @@
// Button debounce with tap and hold event detection, one tick per beat.
//
// in_ch carries one tick per beat: the raw pin level and a resync flag.
// out_ch returns exactly one result beat per tick: the debounced pressed
// state and one-tick down, tap and hold pulses.
// Configuration (polarity, debounce, minimum tap and hold times) is written
// through cfg_wen / cfg_index / cfg_data; the user must do so only while no
// tick is in flight, which the block itself does not enforce.
// A tick accepted on in_ch is registered, evaluated against the button
// state and written to the result register that drives out_ch. Throughput:
// 1 tick per cycle while out_ch is not stalled. The state update is one
// pass of saturating increments and compares from the input register into
// the result register. A stalled receiver holds the result register; the
// input register still takes one more tick, then in_ch.ready drops until
// the result is taken. Reset clears both valid flags and the button state
// and loads the default configuration (active low, 30 / 30 / 1000 ticks).
`timescale 1ns / 1ps
module button_debounce_tap_hold_top (
    input  logic                          clk,
    input  logic                          rst_n,
    bdth_in_if.sink                       in_ch,
    bdth_out_if.source                    out_ch,
    input  logic                          cfg_wen,
    input  logic [bdth_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bdth_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bdth_pkg::*;

    // Configuration
    logic   active_low_reg;
    ticks_t debounce_ticks_reg;
    ticks_t min_tap_ticks_reg;
    ticks_t hold_ticks_reg;

    // Input register
    logic in_valid_reg;
    logic raw_level_reg;
    logic resync_reg;

    // Button state
    logic   last_raw_reg,       last_raw_next;
    logic   stable_level_reg,   stable_level_next;
    timer_t since_change_reg,   since_change_next;
    timer_t press_time_reg,     press_time_next;
    logic   hold_done_reg,      hold_done_next;
    logic   saw_press_edge_reg, saw_press_edge_next;

    // Result register
    logic out_valid_reg;
    logic is_down_reg;
    logic down_event_reg, down_event_next;
    logic tap_event_reg,  tap_event_next;
    logic hold_event_reg, hold_event_next;

    logic advance;
    logic pressed;

    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign pressed      = active_low_reg ? !raw_level_reg : raw_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg     <= 1'b1;
            debounce_ticks_reg <= RST_DEBOUNCE_TICKS;
            min_tap_ticks_reg  <= RST_MIN_TAP_TICKS;
            hold_ticks_reg     <= RST_HOLD_TICKS;
        end
        else if (cfg_wen)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ACTIVE_LOW:     active_low_reg     <= cfg_data[0];
                CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data;
                CFG_MIN_TAP_TICKS:  min_tap_ticks_reg  <= cfg_data;
                CFG_HOLD_TICKS:     hold_ticks_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        timer_t pt_inc;
        logic   settle;

        last_raw_next       = last_raw_reg;
        stable_level_next   = stable_level_reg;
        since_change_next   = since_change_reg;
        press_time_next     = press_time_reg;
        hold_done_next      = hold_done_reg;
        saw_press_edge_next = saw_press_edge_reg;
        down_event_next     = 1'b0;
        tap_event_next      = 1'b0;
        hold_event_next     = 1'b0;
        pt_inc              = sat_inc(press_time_reg);
        settle              = 1'b0;

        if (resync_reg)
        begin
            last_raw_next       = pressed;
            stable_level_next   = pressed;
            since_change_next   = '0;
            press_time_next     = '0;
            hold_done_next      = 1'b0;
            saw_press_edge_next = 1'b0;
        end
        else
        begin
            press_time_next = pt_inc;
            if (pressed != last_raw_reg)
            begin
                last_raw_next     = pressed;
                since_change_next = '0;
            end
            else
            begin
                since_change_next = sat_inc(since_change_reg);
            end

            settle = timer_ge(since_change_next, debounce_ticks_reg) &&
                     (stable_level_reg != last_raw_next);
            if (settle)
            begin
                stable_level_next = last_raw_next;
                if (last_raw_next)
                begin
                    press_time_next     = '0;
                    hold_done_next      = 1'b0;
                    saw_press_edge_next = 1'b1;
                    down_event_next     = 1'b1;
                end
                else
                begin
                    tap_event_next = saw_press_edge_reg && !hold_done_reg &&
                                     timer_ge(pt_inc, min_tap_ticks_reg);
                    saw_press_edge_next = 1'b0;
                end
            end

            if (stable_level_next && !hold_done_next &&
                timer_ge(press_time_next, hold_ticks_reg))
            begin
                hold_done_next  = 1'b1;
                hold_event_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            last_raw_reg       <= 1'b0;
            stable_level_reg   <= 1'b0;
            since_change_reg   <= '0;
            press_time_reg     <= '0;
            hold_done_reg      <= 1'b0;
            saw_press_edge_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                last_raw_reg       <= last_raw_next;
                stable_level_reg   <= stable_level_next;
                since_change_reg   <= since_change_next;
                press_time_reg     <= press_time_next;
                hold_done_reg      <= hold_done_next;
                saw_press_edge_reg <= saw_press_edge_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            raw_level_reg <= in_ch.raw_level;
            resync_reg    <= in_ch.resync;
        end
        if (advance)
        begin
            is_down_reg    <= stable_level_next;
            down_event_reg <= down_event_next;
            tap_event_reg  <= tap_event_next;
            hold_event_reg <= hold_event_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.is_down    = is_down_reg;
    assign out_ch.down_event = down_event_reg;
    assign out_ch.tap_event  = tap_event_reg;
    assign out_ch.hold_event = hold_event_reg;

endmodule

@@ sv/bdth_checker.sv @@
// Port-level checks for the button debounce block, bound to the top level.
`timescale 1ns / 1ps
module bdth_checker (
    input logic        clk,
    input logic        rst_n,
    bdth_in_if.sink    in_ch,
    bdth_out_if.source out_ch
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=>
            (out_ch.valid && $stable(out_ch.is_down) && $stable(out_ch.down_event)
             && $stable(out_ch.tap_event) && $stable(out_ch.hold_event)))
        else $error("result beat changed while stalled");

    // A down pulse only comes with the pressed state.
    a_down_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.down_event) |-> out_ch.is_down)
        else $error("down pulse without pressed state");

    // A tap is reported on release.
    a_tap_released: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.tap_event) |-> !out_ch.is_down)
        else $error("tap pulse while still pressed");

    // A hold fires only while pressed.
    a_hold_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.hold_event) |-> out_ch.is_down)
        else $error("hold pulse while released");

    // With the output side drained, the block takes a tick.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_ch.valid && $past(!out_ch.valid) && $past(!in_ch.valid)) |-> in_ch.ready)
        else $error("input stalled while block is empty");

endmodule

bind button_debounce_tap_hold_top bdth_checker u_bdth_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);

@@ dv/bdth_event_checker.sv @@
// Scoreboard for the debounce / tap / hold block: mirrors the button state and checks result beats.
`timescale 1ns / 1ps
module bdth_event_checker
    import bdth_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    bdth_in_if.monitor             in_ch,
    bdth_out_if.monitor            out_ch,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     outstanding
);

    typedef struct packed {
        logic is_down;
        logic down_event;
        logic tap_event;
        logic hold_event;
    } tick_events_t;

    // Register mirror
    logic   polarity_low;
    ticks_t debounce_lim;
    ticks_t min_tap_lim;
    ticks_t hold_lim;

    // Button state mirror
    logic   last_pressed;
    logic   stable_pressed;
    timer_t unchanged_ticks;
    timer_t pressed_ticks;
    logic   hold_fired;
    logic   press_edge_seen;

    tick_events_t expected_events[$];
    int fail_tally    = 0;
    int pending_count = 0;

    assign mismatches  = fail_tally;
    assign outstanding = pending_count;

    function automatic timer_t saturate_up(input timer_t v);
        return (v == {TIMER_WIDTH{1'b1}}) ? v : v + timer_t'(1);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        fail_tally++;
    endtask

    task automatic check_field(input string field, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("%s got %b expected %b", field, got, want));
    endtask

    // Counters advance first, then the debounce decision, then the hold check.
    task automatic advance_button(input logic lvl, input logic rs, output tick_events_t ev);
        logic pressed;
        pressed = polarity_low ? ~lvl : lvl;
        ev = '0;
        if (rs)
        begin
            last_pressed    = pressed;
            stable_pressed  = pressed;
            unchanged_ticks = '0;
            pressed_ticks   = '0;
            hold_fired      = 1'b0;
            press_edge_seen = 1'b0;
        end
        else
        begin
            pressed_ticks = saturate_up(pressed_ticks);
            if (pressed != last_pressed)
            begin
                last_pressed    = pressed;
                unchanged_ticks = '0;
            end
            else
            begin
                unchanged_ticks = saturate_up(unchanged_ticks);
            end

            if (unchanged_ticks >= debounce_lim && stable_pressed != last_pressed)
            begin
                stable_pressed = last_pressed;
                if (stable_pressed)
                begin
                    pressed_ticks   = '0;
                    hold_fired      = 1'b0;
                    press_edge_seen = 1'b1;
                    ev.down_event   = 1'b1;
                end
                else
                begin
                    if (press_edge_seen && !hold_fired && pressed_ticks >= min_tap_lim)
                        ev.tap_event = 1'b1;
                    press_edge_seen = 1'b0;
                end
            end

            if (stable_pressed && !hold_fired && pressed_ticks >= hold_lim)
            begin
                hold_fired    = 1'b1;
                ev.hold_event = 1'b1;
            end
        end
        ev.is_down = stable_pressed;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_events_t produced;
        tick_events_t wanted;
        if (!rst_n)
        begin
            polarity_low    = 1'b1;
            debounce_lim    = RST_DEBOUNCE_TICKS;
            min_tap_lim     = RST_MIN_TAP_TICKS;
            hold_lim        = RST_HOLD_TICKS;
            last_pressed    = 1'b0;
            stable_pressed  = 1'b0;
            unchanged_ticks = '0;
            pressed_ticks   = '0;
            hold_fired      = 1'b0;
            press_edge_seen = 1'b0;
            expected_events.delete();
            pending_count   = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_ACTIVE_LOW:     polarity_low = cfg_data[0];
                    CFG_DEBOUNCE_TICKS: debounce_lim = cfg_data;
                    CFG_MIN_TAP_TICKS:  min_tap_lim  = cfg_data;
                    CFG_HOLD_TICKS:     hold_lim     = cfg_data;
                    default: ;
                endcase
            end

            if (in_ch.valid && in_ch.ready)
            begin
                advance_button(in_ch.raw_level, in_ch.resync, wanted);
                expected_events.push_back(wanted);
            end

            if (out_ch.valid && out_ch.ready)
            begin
                produced = {out_ch.is_down, out_ch.down_event, out_ch.tap_event,
                            out_ch.hold_event};
                if (expected_events.size() == 0)
                begin
                    report_mismatch($sformatf("result beat %b with nothing expected", produced));
                end
                else
                begin
                    wanted = expected_events.pop_front();
                    check_field("is_down", produced.is_down, wanted.is_down);
                    check_field("down_event", produced.down_event, wanted.down_event);
                    check_field("tap_event", produced.tap_event, wanted.tap_event);
                    check_field("hold_event", produced.hold_event, wanted.hold_event);
                end
            end
            pending_count = expected_events.size();
        end
    end

endmodule

@@ dv/button_debounce_tap_hold_top_test.sv @@
// Testbench top for the debounce / tap / hold block: clock, reset, tick stimulus and verdict.
`timescale 1ns / 1ps
module button_debounce_tap_hold_top_test;
    import bdth_pkg::*;

    localparam int TICKS_RANDOM = 1650;
    localparam int PHASES       = 8;
    localparam int LONG_PRESS   = 120;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wen   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int fail_count;
    int results_pending;
    int ticks_sent = 0;

    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    bit stall_request   = 1'b0;

    // What has been written, so ticks can be generated as presses
    logic   pol_now  = 1'b1;
    ticks_t deb_now  = RST_DEBOUNCE_TICKS;
    ticks_t hold_now = RST_HOLD_TICKS;

    bdth_in_if  in_ch ();
    bdth_out_if out_ch ();

    button_debounce_tap_hold_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bdth_event_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (fail_count),
        .outstanding (results_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                stall_request = 1'b0;
            end
            out_ch.ready <= receiver_steady || ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic put_tick(input logic lvl, input logic rs);
        int gap;
        if (!sender_steady && $urandom_range(0, 99) < 15)
        begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.raw_level <= lvl;
        in_ch.resync    <= rs;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic put_pressed(input logic pressed, input logic rs);
        put_tick(pressed ^ pol_now, rs);
    endtask

    task automatic drain_results;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
    endtask

    task automatic set_registers(input logic pol, input ticks_t deb, input ticks_t tap,
                                 input ticks_t hold);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_ACTIVE_LOW;
        cfg_data  <= ticks_t'(pol);
        @(posedge clk);
        cfg_index <= CFG_DEBOUNCE_TICKS;
        cfg_data  <= deb;
        @(posedge clk);
        cfg_index <= CFG_MIN_TAP_TICKS;
        cfg_data  <= tap;
        @(posedge clk);
        cfg_index <= CFG_HOLD_TICKS;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_wen  <= 1'b0;
        pol_now  = pol;
        deb_now  = deb;
        hold_now = hold;
    endtask

    // Contact bounce, a held press (sometimes resynced midway), bounce, a release
    task automatic press_cycle;
        int bounces;
        int press_span;
        int press_len;
        int rel_len;
        int resync_at;
        int n;
        bounces    = $urandom_range(0, 3);
        press_span = int'(hold_now) + int'(deb_now) + 6;
        if (press_span > 120)
            press_span = 120;
        press_len  = $urandom_range(0, press_span);
        resync_at  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, press_len) : -1;
        rel_len    = int'(deb_now) * 2 + 4;
        if (rel_len > 80)
            rel_len = 80;
        rel_len    = $urandom_range(0, rel_len);

        repeat (bounces)
        begin
            put_pressed(1'b1, 1'b0);
            put_pressed(1'b0, 1'b0);
        end
        for (n = 0; n < press_len; n++)
            put_pressed(1'b1, n == resync_at);
        repeat (bounces)
        begin
            put_pressed(1'b0, 1'b0);
            put_pressed(1'b1, 1'b0);
        end
        for (n = 0; n < rel_len; n++)
            put_pressed(1'b0, 1'b0);
    endtask

    task automatic noise_burst;
        repeat ($urandom_range(1, 6))
            put_tick(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
    endtask

    initial
    begin : stimulus
        int phase;
        int phase_end;
        in_ch.valid     = 1'b0;
        in_ch.raw_level = 1'b1;
        in_ch.resync    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: active low, idle pin high
        put_tick(1'b1, 1'b0);
        put_tick(1'b0, 1'b0);

        // All times zero: press is stable at once and holds on the same tick
        set_registers(1'b0, 16'd0, 16'd0, 16'd0);
        put_tick(1'b1, 1'b0);
        put_tick(1'b1, 1'b0);
        put_tick(1'b0, 1'b0);

        // Zero minimum tap; resync while pressed blocks the tap
        set_registers(1'b1, 16'd0, 16'd0, 16'hFFFF);
        put_tick(1'b0, 1'b0);
        put_tick(1'b1, 1'b0);
        put_tick(1'b0, 1'b1);
        put_tick(1'b0, 1'b0);
        put_tick(1'b1, 1'b0);
        put_tick(1'b0, 1'b1);
        put_tick(1'b1, 1'b1);

        // Short debounce with bounce and two presses that each reach the hold time
        set_registers(1'b0, 16'd2, 16'd3, 16'd4);
        put_tick(1'b1, 1'b0);
        put_tick(1'b0, 1'b0);
        repeat (7) put_tick(1'b1, 1'b0);
        repeat (3) put_tick(1'b0, 1'b0);
        repeat (6) put_tick(1'b1, 1'b0);
        repeat (3) put_tick(1'b0, 1'b0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: set_registers(1'($urandom_range(0, 1)), 16'd0, 16'd0, 16'd0);
                1: set_registers(1'($urandom_range(0, 1)), ticks_t'($urandom_range(1, 4)),
                                 ticks_t'($urandom_range(0, 6)),
                                 ticks_t'($urandom_range(5, 30)));
                2: set_registers(1'b0, 16'd2, 16'hFFFF, 16'hFFFF);
                3: set_registers(1'b1, 16'd30, 16'd30, 16'd100);
                default: set_registers(1'($urandom_range(0, 1)),
                                       ticks_t'($urandom_range(0, 6)),
                                       ticks_t'($urandom_range(0, 12)),
                                       ticks_t'($urandom_range(0, 50)));
            endcase
            if (phase == 4)
                stall_request = 1'b1;
            phase_end = ticks_sent + TICKS_RANDOM / PHASES;
            while (ticks_sent < phase_end)
            begin
                if ($urandom_range(0, 99) < 85)
                    press_cycle();
                else
                    noise_burst();
            end
        end

        // One long press that reaches the hold time, with no idling on either side
        set_registers(1'b1, 16'd3, 16'd5, 16'd100);
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        repeat (LONG_PRESS) put_pressed(1'b1, 1'b0);
        repeat (6) put_pressed(1'b0, 1'b0);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/bdth_pkg.sv
sv/bdth_if.sv
sv/button_debounce_tap_hold_top.sv
sv/bdth_checker.sv
dv/bdth_event_checker.sv
dv/button_debounce_tap_hold_top_test.sv
